FILE: hw/rtl/prefix_cache_directory_lru_assert.svh
// assertion macros for the prefix cache directory checker file
// no dependencies; included by bare file name
`ifndef PREFIX_CACHE_DIRECTORY_LRU_ASSERT_SVH
`define PREFIX_CACHE_DIRECTORY_LRU_ASSERT_SVH

// same-cycle implication under the active-low reset
`define PCDL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pcdl assertion failed");

// next-cycle implication under the active-low reset
`define PCDL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pcdl assertion failed");

`endif

FILE: hw/rtl/pcdl_pkg.sv
// shared types, widths and codes for the prefix cache directory
// no dependencies; imported by every module of the block
package pcdl_pkg;

  localparam int unsigned DEF_MAX_ENTRIES = 64;

  localparam int unsigned KEY_W   = 64;
  localparam int unsigned STAMP_W = 64;
  localparam int unsigned BLK_W   = 16;
  localparam int unsigned PLEN_W  = 12;
  localparam int unsigned SLOT_W  = 6;
  localparam int unsigned USED_W  = 7;
  localparam int unsigned TOT_W   = 32;

  localparam logic [TOT_W-1:0] TOT_MAX = '1;

  typedef enum logic {
    CMD_STORE = 1'b0,
    CMD_LOAD  = 1'b1
  } pcdl_cmd_e;

  typedef enum logic [1:0] {
    ST_STORED = 2'd0,
    ST_HIT    = 2'd1,
    ST_MISS   = 2'd2,
    ST_BAD    = 2'd3
  } pcdl_status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_UPDATE
  } pcdl_state_e;

  // per-array write enables of the entry store
  typedef struct packed {
    logic key;
    logic blocks;
    logic stamp;
  } pcdl_we_t;

  // control of the compare unit
  typedef struct packed {
    logic clear;
    logic valid;
  } pcdl_scan_ctl_t;

endpackage

FILE: hw/rtl/pcdl_mem.sv
// entry store: key, block count and stamp arrays, one write and one read port
// depends on pcdl_pkg
module pcdl_mem import pcdl_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = DEF_MAX_ENTRIES,
  localparam int unsigned IDX_W = $clog2(MAX_ENTRIES)
) (
  input  logic               clk_i,
  input  pcdl_we_t           we_i,
  input  logic [IDX_W-1:0]   wr_addr_i,
  input  logic [KEY_W-1:0]   wr_key_i,
  input  logic [BLK_W-1:0]   wr_blocks_i,
  input  logic [STAMP_W-1:0] wr_stamp_i,
  input  logic               rd_en_i,
  input  logic [IDX_W-1:0]   rd_addr_i,
  output logic [KEY_W-1:0]   rd_key_o,
  output logic [BLK_W-1:0]   rd_blocks_o,
  output logic [STAMP_W-1:0] rd_stamp_o
);

  logic [KEY_W-1:0]   key_mem   [MAX_ENTRIES];
  logic [BLK_W-1:0]   blocks_mem[MAX_ENTRIES];
  logic [STAMP_W-1:0] stamp_mem [MAX_ENTRIES];

  logic [KEY_W-1:0]   rd_key_q;
  logic [BLK_W-1:0]   rd_blocks_q;
  logic [STAMP_W-1:0] rd_stamp_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i.key) begin
      key_mem[wr_addr_i] <= wr_key_i;
    end
    if (we_i.blocks) begin
      blocks_mem[wr_addr_i] <= wr_blocks_i;
    end
    if (we_i.stamp) begin
      stamp_mem[wr_addr_i] <= wr_stamp_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_key_q    <= key_mem[rd_addr_i];
      rd_blocks_q <= blocks_mem[rd_addr_i];
      rd_stamp_q  <= stamp_mem[rd_addr_i];
    end
  end

  assign rd_key_o    = rd_key_q;
  assign rd_blocks_o = rd_blocks_q;
  assign rd_stamp_o  = rd_stamp_q;

endmodule

FILE: hw/rtl/pcdl_scan.sv
// compare unit: key match and oldest-stamp search, one entry per cycle
// depends on pcdl_pkg
module pcdl_scan import pcdl_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = DEF_MAX_ENTRIES,
  localparam int unsigned IDX_W = $clog2(MAX_ENTRIES)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pcdl_scan_ctl_t     ctl_i,
  input  logic [IDX_W-1:0]   idx_i,
  input  logic [KEY_W-1:0]   ref_key_i,
  input  logic [KEY_W-1:0]   key_i,
  input  logic [STAMP_W-1:0] stamp_i,
  input  logic [BLK_W-1:0]   blocks_i,
  output logic               found_o,
  output logic [IDX_W-1:0]   hit_idx_o,
  output logic [BLK_W-1:0]   hit_blocks_o,
  output logic [IDX_W-1:0]   lru_idx_o
);

  logic               found_q, found_d;
  logic [IDX_W-1:0]   hit_idx_q;
  logic [BLK_W-1:0]   hit_blocks_q;
  logic [IDX_W-1:0]   lru_idx_q;
  logic [STAMP_W-1:0] min_stamp_q;
  logic               take_hit;
  logic               take_min;

  // first matching key wins; oldest stamp taken only when strictly smaller
  always_comb begin
    take_hit = ctl_i.valid && !found_q && (key_i == ref_key_i);
    take_min = ctl_i.valid && ((idx_i == '0) || (stamp_i < min_stamp_q));
    found_d  = found_q;
    if (ctl_i.clear) begin
      found_d = 1'b0;
    end else if (take_hit) begin
      found_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else begin
      found_q <= found_d;
    end
  end

  // hit and candidate payload
  always_ff @(posedge clk_i) begin
    if (take_hit) begin
      hit_idx_q    <= idx_i;
      hit_blocks_q <= blocks_i;
    end
    if (take_min) begin
      lru_idx_q   <= idx_i;
      min_stamp_q <= stamp_i;
    end
  end

  assign found_o      = found_q;
  assign hit_idx_o    = hit_idx_q;
  assign hit_blocks_o = hit_blocks_q;
  assign lru_idx_o    = lru_idx_q;

endmodule

FILE: hw/rtl/prefix_cache_directory_lru.sv
// prefix cache directory, fully associative with least-recently-used replacement
// depends on pcdl_pkg, pcdl_mem and pcdl_scan
//
//   channel  direction  handshake                  payload
//   in       input      in_valid_i / in_stall_o    cmd, prefix_key, prefix_length,
//                                                  block_count, block_limit
//   out      output     out_valid_o / out_stall_i  status, slot_index, blocks_out,
//                                                  evicted, entries_used, totals
//
// accept to next accept: a bad argument or a request on an empty directory goes straight
// to the update; otherwise the accepting cycle, one entry a cycle read from the single
// read port below the fill count, the last compare settling, then the update
// the result becomes valid in the same cycle as the input opens again
// no clearing pass after reset; only entries below the fill count are read
// in_stall_o is high while a request is in flight; a stalled result holds the update of
// the next request until it is taken
module prefix_cache_directory_lru import pcdl_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = DEF_MAX_ENTRIES
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              cmd_i,
  input  logic [KEY_W-1:0]  prefix_key_i,
  input  logic [PLEN_W-1:0] prefix_length_i,
  input  logic [BLK_W-1:0]  block_count_i,
  input  logic [BLK_W-1:0]  block_limit_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        status_o,
  output logic [SLOT_W-1:0] slot_index_o,
  output logic [BLK_W-1:0]  blocks_out_o,
  output logic              evicted_o,
  output logic [USED_W-1:0] entries_used_o,
  output logic [TOT_W-1:0]  hit_total_o,
  output logic [TOT_W-1:0]  miss_total_o,
  output logic [TOT_W-1:0]  eviction_total_o
);

  localparam int unsigned IDX_W = $clog2(MAX_ENTRIES);
  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(MAX_ENTRIES);

  pcdl_state_e state_q, state_d;

  // latched request
  pcdl_cmd_e         cmd_q;
  logic [KEY_W-1:0]  key_q;
  logic [BLK_W-1:0]  count_q;
  logic [BLK_W-1:0]  limit_q;
  logic              bad_q;

  // scan sequencing
  logic [CNT_W-1:0]  scan_cnt_q, scan_cnt_d;
  logic              pend_q;
  logic [IDX_W-1:0]  pend_idx_q;
  logic              issue;

  // directory state
  logic [CNT_W-1:0]   used_q, used_d;
  logic [STAMP_W-1:0] clock_q, clock_d;
  logic [TOT_W-1:0]   hit_q, hit_d;
  logic [TOT_W-1:0]   miss_q, miss_d;
  logic [TOT_W-1:0]   evict_q, evict_d;

  // result register
  logic               out_valid_q, out_valid_d;
  pcdl_status_e       status_q, status_d;
  logic [SLOT_W-1:0]  slot_q, slot_d;
  logic [BLK_W-1:0]   blocks_q, blocks_d;
  logic               evicted_q, evicted_d;

  logic               in_acc;
  logic               bad_arg;
  logic               out_free;
  logic               do_upd;

  // memory and compare unit wiring
  pcdl_we_t           mem_we;
  logic [IDX_W-1:0]   wr_addr;
  logic [KEY_W-1:0]   rd_key;
  logic [BLK_W-1:0]   rd_blocks;
  logic [STAMP_W-1:0] rd_stamp;
  pcdl_scan_ctl_t     scan_ctl;
  logic               found;
  logic [IDX_W-1:0]   hit_idx;
  logic [BLK_W-1:0]   hit_blocks;
  logic [IDX_W-1:0]   lru_idx;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign do_upd     = (state_q == S_UPDATE) && out_free;
  assign issue      = (state_q == S_SCAN) && (scan_cnt_q < used_q);

  // argument check on the incoming request
  always_comb begin
    bad_arg = (prefix_length_i == '0) ||
              ((cmd_i == CMD_STORE) && (block_count_i == '0)) ||
              ((cmd_i == CMD_LOAD) && (block_limit_i == '0));
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (bad_arg || (used_q == '0)) begin
            state_d = S_UPDATE;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if ((scan_cnt_q == used_q) && !pend_q) begin
          state_d = S_UPDATE;
        end
      end
      S_UPDATE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // scan address counter
  always_comb begin
    scan_cnt_d = scan_cnt_q;
    if (in_acc) begin
      scan_cnt_d = '0;
    end else if (issue) begin
      scan_cnt_d = scan_cnt_q + 1'b1;
    end
  end

  assign scan_ctl = '{clear: in_acc, valid: pend_q};

  // update: entry writes, counters and result
  always_comb begin
    mem_we      = '0;
    wr_addr     = hit_idx;
    used_d      = used_q;
    clock_d     = clock_q;
    hit_d       = hit_q;
    miss_d      = miss_q;
    evict_d     = evict_q;
    out_valid_d = out_valid_q && out_stall_i;
    status_d    = status_q;
    slot_d      = slot_q;
    blocks_d    = blocks_q;
    evicted_d   = evicted_q;
    if (do_upd) begin
      out_valid_d = 1'b1;
      status_d    = ST_BAD;
      slot_d      = '0;
      blocks_d    = '0;
      evicted_d   = 1'b0;
      if (bad_q) begin
        status_d = ST_BAD;
      end else if (cmd_q == CMD_STORE) begin
        clock_d = clock_q + 1'b1;
        mem_we  = '{key: 1'b1, blocks: 1'b1, stamp: 1'b1};
        if (found) begin
          wr_addr = hit_idx;
        end else if (used_q != FULL) begin
          wr_addr = used_q[IDX_W-1:0];
          used_d  = used_q + 1'b1;
        end else begin
          wr_addr   = lru_idx;
          evicted_d = 1'b1;
          evict_d   = (evict_q == TOT_MAX) ? evict_q : evict_q + 1'b1;
        end
        status_d = ST_STORED;
        slot_d   = SLOT_W'(wr_addr);
        blocks_d = count_q;
      end else if (found) begin
        clock_d  = clock_q + 1'b1;
        mem_we   = '{key: 1'b0, blocks: 1'b0, stamp: 1'b1};
        wr_addr  = hit_idx;
        hit_d    = (hit_q == TOT_MAX) ? hit_q : hit_q + 1'b1;
        status_d = ST_HIT;
        slot_d   = SLOT_W'(hit_idx);
        blocks_d = (hit_blocks > limit_q) ? limit_q : hit_blocks;
      end else begin
        miss_d   = (miss_q == TOT_MAX) ? miss_q : miss_q + 1'b1;
        status_d = ST_MISS;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      scan_cnt_q  <= '0;
      pend_q      <= 1'b0;
      used_q      <= '0;
      clock_q     <= '0;
      hit_q       <= '0;
      miss_q      <= '0;
      evict_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      scan_cnt_q  <= scan_cnt_d;
      pend_q      <= issue;
      used_q      <= used_d;
      clock_q     <= clock_d;
      hit_q       <= hit_d;
      miss_q      <= miss_d;
      evict_q     <= evict_d;
      out_valid_q <= out_valid_d;
    end
  end

  // request and result payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q   <= pcdl_cmd_e'(cmd_i);
      key_q   <= prefix_key_i;
      count_q <= block_count_i;
      limit_q <= block_limit_i;
      bad_q   <= bad_arg;
    end
    pend_idx_q <= scan_cnt_q[IDX_W-1:0];
    status_q   <= status_d;
    slot_q     <= slot_d;
    blocks_q   <= blocks_d;
    evicted_q  <= evicted_d;
  end

  pcdl_mem #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_mem (
    .clk_i      (clk_i),
    .we_i       (mem_we),
    .wr_addr_i  (wr_addr),
    .wr_key_i   (key_q),
    .wr_blocks_i(count_q),
    .wr_stamp_i (clock_d),
    .rd_en_i    (issue),
    .rd_addr_i  (scan_cnt_q[IDX_W-1:0]),
    .rd_key_o   (rd_key),
    .rd_blocks_o(rd_blocks),
    .rd_stamp_o (rd_stamp)
  );

  pcdl_scan #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (scan_ctl),
    .idx_i       (pend_idx_q),
    .ref_key_i   (key_q),
    .key_i       (rd_key),
    .stamp_i     (rd_stamp),
    .blocks_i    (rd_blocks),
    .found_o     (found),
    .hit_idx_o   (hit_idx),
    .hit_blocks_o(hit_blocks),
    .lru_idx_o   (lru_idx)
  );

  // totals and fill count only move together with a new result
  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign slot_index_o     = slot_q;
  assign blocks_out_o     = blocks_q;
  assign evicted_o        = evicted_q;
  assign entries_used_o   = USED_W'(used_q);
  assign hit_total_o      = hit_q;
  assign miss_total_o     = miss_q;
  assign eviction_total_o = evict_q;

endmodule

FILE: hw/rtl/pcdl_checker.sv
// port-level checker for the prefix cache directory, bound to the top level
// depends on pcdl_pkg and prefix_cache_directory_lru_assert.svh
`include "prefix_cache_directory_lru_assert.svh"

module pcdl_checker import pcdl_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = DEF_MAX_ENTRIES
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [1:0]        status_o,
  input logic [SLOT_W-1:0] slot_index_o,
  input logic [BLK_W-1:0]  blocks_out_o,
  input logic              evicted_o,
  input logic [USED_W-1:0] entries_used_o,
  input logic [TOT_W-1:0]  hit_total_o
);

  logic res_bad;
  logic res_miss;
  logic res_hit;

  assign res_bad  = out_valid_o && (status_o == ST_BAD);
  assign res_miss = out_valid_o && (status_o == ST_MISS);
  assign res_hit  = out_valid_o && (status_o == ST_HIT);

  // a stalled result holds
  `PCDL_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
    out_valid_o && $stable(status_o) && $stable(slot_index_o) &&
    $stable(blocks_out_o) && $stable(hit_total_o))

  // a request in flight keeps the input side closed
  `PCDL_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o,
    in_stall_o)

  // a bad argument or a miss reports nothing
  `PCDL_ASSERT_NOW(a_empty_result, clk_i, rst_ni, res_bad || res_miss,
    (slot_index_o == '0) && (blocks_out_o == '0) && !evicted_o)

  // eviction only on a store into a full directory
  `PCDL_ASSERT_NOW(a_evict_full, clk_i, rst_ni, out_valid_o && evicted_o,
    (status_o == ST_STORED) && (entries_used_o == USED_W'(MAX_ENTRIES)))

  // a hit returns a non-zero count and a non-zero hit total
  `PCDL_ASSERT_NOW(a_hit_nonzero, clk_i, rst_ni, res_hit,
    (blocks_out_o != '0) && (hit_total_o != '0))

endmodule

bind prefix_cache_directory_lru pcdl_checker #(
  .MAX_ENTRIES(MAX_ENTRIES)
) u_pcdl_checker (.*);

FILE: bench/testbench.sv
`timescale 1ns / 100ps
// testbench for prefix_cache_directory_lru: directed and random store and load requests
// checked against a behavioural directory model kept in step with accepted requests
// depends on pcdl_pkg and the directory rtl
module testbench import pcdl_pkg::*;;

  localparam int unsigned DIR_DEPTH    = DEF_MAX_ENTRIES;
  localparam int unsigned POOL_SIZE    = 112;
  localparam int unsigned HOLD_CYCLES  = 600;
  localparam int unsigned DRAIN_CYCLES = 80;
  localparam int unsigned TIMEOUT_NS   = 15_000_000;

  typedef struct {
    pcdl_status_e      status;
    logic [SLOT_W-1:0] slot;
    logic [BLK_W-1:0]  blocks;
    logic              evicted;
    logic [USED_W-1:0] used;
    logic [TOT_W-1:0]  hits;
    logic [TOT_W-1:0]  misses;
    logic [TOT_W-1:0]  evictions;
  } dir_result_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic              cmd_i = 1'b0;
  logic [KEY_W-1:0]  prefix_key_i = '0;
  logic [PLEN_W-1:0] prefix_length_i = '0;
  logic [BLK_W-1:0]  block_count_i = '0;
  logic [BLK_W-1:0]  block_limit_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [1:0]        status_o;
  logic [SLOT_W-1:0] slot_index_o;
  logic [BLK_W-1:0]  blocks_out_o;
  logic              evicted_o;
  logic [USED_W-1:0] entries_used_o;
  logic [TOT_W-1:0]  hit_total_o;
  logic [TOT_W-1:0]  miss_total_o;
  logic [TOT_W-1:0]  eviction_total_o;

  // model of the directory contents
  logic [KEY_W-1:0]   dir_key    [DIR_DEPTH];
  logic [BLK_W-1:0]   dir_blocks [DIR_DEPTH];
  logic [STAMP_W-1:0] dir_stamp  [DIR_DEPTH];
  int unsigned        dir_used = 0;
  logic [STAMP_W-1:0] dir_clock = '0;
  logic [TOT_W-1:0]   dir_hits = '0;
  logic [TOT_W-1:0]   dir_misses = '0;
  logic [TOT_W-1:0]   dir_evictions = '0;

  dir_result_t       pending_results [$];
  dir_result_t       oldest_expected;
  int unsigned       error_count = 0;
  logic [KEY_W-1:0]  key_pool [POOL_SIZE];

  int unsigned sender_idle_pct = 0;
  int unsigned receiver_stall_pct = 0;
  int unsigned hold_requests = 0;
  int unsigned hold_served = 0;
  int unsigned hold_left = 0;

  prefix_cache_directory_lru u_dut (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_o,
    .cmd_i, .prefix_key_i, .prefix_length_i, .block_count_i, .block_limit_i,
    .out_valid_o, .out_stall_i,
    .status_o, .slot_index_o, .blocks_out_o, .evicted_o, .entries_used_o,
    .hit_total_o, .miss_total_o, .eviction_total_o
  );

  // clock, 12 ns period
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic logic [TOT_W-1:0] bump_total(logic [TOT_W-1:0] count);
    return (count == TOT_MAX) ? count : count + 1'b1;
  endfunction

  // apply one request to the model directory and return the result it gives
  function automatic dir_result_t directory_access(pcdl_cmd_e op, logic [KEY_W-1:0] key,
      logic [PLEN_W-1:0] plen, logic [BLK_W-1:0] count, logic [BLK_W-1:0] limit);
    dir_result_t        r;
    int                 match;
    int unsigned        slot;
    logic [STAMP_W-1:0] oldest;
    r.status  = ST_BAD;
    r.slot    = '0;
    r.blocks  = '0;
    r.evicted = 1'b0;
    match     = -1;
    slot      = 0;
    if (plen != '0 && !(op == CMD_STORE && count == '0) && !(op == CMD_LOAD && limit == '0)) begin
      for (int i = 0; i < dir_used; i++) begin
        if (match < 0 && dir_key[i] == key) match = i;
      end
      if (op == CMD_STORE) begin
        if (match >= 0) begin
          slot = match;
        end else if (dir_used < DIR_DEPTH) begin
          slot = dir_used;
          dir_used++;
        end else begin
          // least recently used entry, lowest index wins a tie
          oldest = dir_stamp[0];
          for (int i = 1; i < DIR_DEPTH; i++) begin
            if (dir_stamp[i] < oldest) begin
              oldest = dir_stamp[i];
              slot   = i;
            end
          end
          dir_evictions = bump_total(dir_evictions);
          r.evicted     = 1'b1;
        end
        dir_clock++;
        dir_key[slot]    = key;
        dir_blocks[slot] = count;
        dir_stamp[slot]  = dir_clock;
        r.status = ST_STORED;
        r.slot   = slot[SLOT_W-1:0];
        r.blocks = count;
      end else if (match < 0) begin
        dir_misses = bump_total(dir_misses);
        r.status   = ST_MISS;
      end else begin
        slot = match;
        dir_clock++;
        dir_stamp[slot] = dir_clock;
        dir_hits = bump_total(dir_hits);
        r.status = ST_HIT;
        r.slot   = slot[SLOT_W-1:0];
        r.blocks = (dir_blocks[slot] > limit) ? limit : dir_blocks[slot];
      end
    end
    r.used      = dir_used[USED_W-1:0];
    r.hits      = dir_hits;
    r.misses    = dir_misses;
    r.evictions = dir_evictions;
    return r;
  endfunction

  // offer one request, wait for it to be taken, then maybe go idle
  task automatic send_request(pcdl_cmd_e op, logic [KEY_W-1:0] key, logic [PLEN_W-1:0] plen,
      logic [BLK_W-1:0] count, logic [BLK_W-1:0] limit);
    in_valid_i      <= 1'b1;
    cmd_i           <= op;
    prefix_key_i    <= key;
    prefix_length_i <= plen;
    block_count_i   <= count;
    block_limit_i   <= limit;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_results.push_back(directory_access(op, key, plen, count, limit));
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 90)) @(posedge clk_i);
    end
  endtask

  // random request, key mostly from the first pool_size keys of the pool
  task automatic send_random_request(int unsigned pool_size);
    pcdl_cmd_e         op;
    logic [KEY_W-1:0]  key;
    logic [PLEN_W-1:0] plen;
    logic [BLK_W-1:0]  count;
    logic [BLK_W-1:0]  limit;
    int unsigned       pick;
    op   = ($urandom_range(99) < 45) ? CMD_STORE : CMD_LOAD;
    key  = ($urandom_range(99) < 90) ? key_pool[$urandom_range(pool_size - 1)]
                                     : {$urandom, $urandom};
    pick = $urandom_range(99);
    plen = (pick < 3) ? '0 : (pick < 8) ? '1 : PLEN_W'($urandom_range(1, 4095));
    pick = $urandom_range(99);
    count = (pick < 3) ? '0 : (pick < 50) ? BLK_W'($urandom_range(1, 64))
                                          : BLK_W'($urandom_range(1, 65535));
    pick = $urandom_range(99);
    limit = (pick < 3) ? '0 : (pick < 50) ? BLK_W'($urandom_range(1, 64))
                                          : BLK_W'($urandom_range(1, 65535));
    send_request(op, key, plen, count, limit);
  endtask

  // each bad argument form, then a load on the empty directory
  task automatic test_bad_arguments();
    send_request(CMD_LOAD, '0, '0, 16'd5, 16'd5);
    send_request(CMD_STORE, {$urandom, $urandom}, '0, 16'd5, 16'd5);
    send_request(CMD_STORE, '1, 12'd1, '0, '1);
    send_request(CMD_LOAD, '1, '1, '1, '0);
    send_request(CMD_LOAD, '0, 12'd1, '0, 16'd1);
  endtask

  // field extremes, overwrite, clamping and near-miss keys
  task automatic test_store_and_load();
    send_request(CMD_STORE, '1, '1, '1, '0);
    send_request(CMD_STORE, '0, 12'd1, 16'd1, '1);
    send_request(CMD_LOAD, '1, 12'd1, '0, 16'd1);
    send_request(CMD_LOAD, '1, 12'd9, '0, '1);
    send_request(CMD_STORE, '0, 12'd77, 16'd300, 16'd2);
    send_request(CMD_LOAD, '0, 12'd3, 16'd8, 16'd300);
    send_request(CMD_LOAD, '0, 12'd3, 16'd8, 16'd299);
    send_request(CMD_LOAD, 64'd1, 12'd3, 16'd8, 16'd299);
    send_request(CMD_STORE, {1'b1, 63'd0}, '1, '0, '1);
    send_request(CMD_LOAD, {1'b0, {63{1'b1}}}, '1, '1, '1);
    send_request(CMD_STORE, '0, 12'd2048, 16'd1, 16'd1);
    send_request(CMD_LOAD, '0, 12'd2048, '1, '1);
  endtask

  // fill every entry, refresh some, then force least-recently-used replacement
  task automatic test_fill_and_evict();
    logic [KEY_W-1:0] fresh [80];
    for (int i = 0; i < 80; i++) fresh[i] = {$urandom, $urandom};
    for (int i = 0; i < 62; i++) begin
      send_request(CMD_STORE, fresh[i], PLEN_W'($urandom_range(1, 4095)),
                   BLK_W'($urandom_range(1, 65535)), BLK_W'($urandom));
    end
    for (int i = 0; i < 10; i++) begin
      send_request(CMD_LOAD, fresh[i * 3], PLEN_W'($urandom_range(1, 4095)),
                   BLK_W'($urandom), BLK_W'($urandom_range(1, 65535)));
    end
    for (int i = 62; i < 80; i++) begin
      send_request(CMD_STORE, fresh[i], PLEN_W'($urandom_range(1, 4095)),
                   BLK_W'($urandom_range(1, 65535)), BLK_W'($urandom));
    end
    for (int i = 0; i < 20; i++) begin
      send_request(CMD_LOAD, fresh[$urandom_range(79)], PLEN_W'($urandom_range(1, 4095)),
                   BLK_W'($urandom), BLK_W'($urandom_range(1, 65535)));
    end
  endtask

  task automatic test_random_traffic(int unsigned idle_pct, int unsigned stall_pct,
      int unsigned pool_size, int unsigned requests);
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    repeat (requests) send_random_request(pool_size);
  endtask

  // long receiver hold while requests keep coming, so the input stalls
  task automatic test_backpressure();
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    hold_requests++;
    repeat (16) send_random_request(48);
  endtask

  // receiver: random stalls, or a long hold when one is asked for
  always @(posedge clk_i) begin
    if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left   <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < receiver_stall_pct);
    end
  end

  function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      error_count++;
      $display("%0t %s expected %0h actual %0h", $time, name, want, got);
    end
  endfunction

  // compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t unexpected result, status %0d slot %0d", $time, status_o, slot_index_o);
      end else begin
        oldest_expected = pending_results.pop_front();
        compare_field("status", oldest_expected.status, status_o);
        compare_field("slot_index", oldest_expected.slot, slot_index_o);
        compare_field("blocks_out", oldest_expected.blocks, blocks_out_o);
        compare_field("evicted", oldest_expected.evicted, evicted_o);
        compare_field("entries_used", oldest_expected.used, entries_used_o);
        compare_field("hit_total", oldest_expected.hits, hit_total_o);
        compare_field("miss_total", oldest_expected.misses, miss_total_o);
        compare_field("eviction_total", oldest_expected.evictions, eviction_total_o);
      end
    end
  end

  // watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("FAILURE");
    $finish;
  end

  initial begin
    // key pool, every fourth key one bit away from its neighbour
    for (int i = 0; i < POOL_SIZE; i++) begin
      key_pool[i] = (i % 4 == 3) ? key_pool[i - 1] ^ (64'd1 << $urandom_range(63))
                                 : {$urandom, $urandom};
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_bad_arguments();
    test_store_and_load();
    test_fill_and_evict();
    test_random_traffic(0, 0, 40, 320);
    test_random_traffic(57, 0, 80, 320);
    test_random_traffic(0, 57, 112, 320);
    test_random_traffic(31, 31, 64, 320);
    test_backpressure();
    test_random_traffic(0, 0, 56, 40);

    // drain
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
